### rtl/flp_pkg.sv
// Shared types, constants and helper functions for the fixed-point lerp core.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package flp_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_SIGNED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_WIDTH = 2'd2;

    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;

    typedef enum logic [1:0] {
        WIDTH_8,
        WIDTH_16,
        WIDTH_32
    } width_t;

    typedef struct packed {
        width_t value_width;
        logic   value_signed;
        width_t weight_width;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] tw;
        logic [DATA_W-1:0] iw;
    } wt_item_t;

    typedef struct packed {
        logic [PROD_W-1:0] p;
        logic [PROD_W-1:0] ph;
    } mac_item_t;

    function automatic width_t mode_to_width(input logic [1:0] mode);
        width_t widest;
        width_t result;
        widest = (MAX_WIDTH >= 32) ? WIDTH_32 : ((MAX_WIDTH >= 16) ? WIDTH_16 : WIDTH_8);
        case (mode)
            MODE_8:  result = WIDTH_8;
            MODE_16: result = (MAX_WIDTH >= 16) ? WIDTH_16 : WIDTH_8;
            default: result = widest;
        endcase
        return result;
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(input width_t w);
        logic [DATA_W-1:0] result;
        case (w)
            WIDTH_8:  result = 32'h0000_00FF;
            WIDTH_16: result = 32'h0000_FFFF;
            default:  result = 32'hFFFF_FFFF;
        endcase
        return result;
    endfunction

    function automatic logic [DATA_W-1:0] top_bit(input width_t w);
        logic [DATA_W-1:0] result;
        case (w)
            WIDTH_8:  result = 32'h0000_0080;
            WIDTH_16: result = 32'h0000_8000;
            default:  result = 32'h8000_0000;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

### rtl/flp_weight_scale.sv
// Stages 1-2: bias and mask the values, rescale the weight to the value width.
// Depends on flp_pkg.
`default_nettype none

module flp_weight_scale (
    input  wire                     clk,
    input  wire                     rst_n,
    input  flp_pkg::cfg_t           cfg,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [31:0]             start_value,
    input  wire  [31:0]             end_value,
    input  wire  [31:0]             blend_weight,
    output logic                    out_valid,
    input  wire                     out_ready,
    output flp_pkg::wt_item_t       out_item
);
    import flp_pkg::*;

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_a_reg;
    logic [DATA_W-1:0] s1_b_reg;
    logic [DATA_W-1:0] s1_w_reg;
    logic              s2_valid_reg;
    wt_item_t          s2_item_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic [DATA_W-1:0] vmask;
    logic [DATA_W-1:0] bias;
    logic [DATA_W-1:0] w_masked;
    logic [15:0]       q65537;
    logic [DATA_W-1:0] s1_a_next;
    logic [DATA_W-1:0] s1_b_next;
    logic [DATA_W-1:0] s1_w_next;
    logic [7:0]        q257;
    logic              need_div257;
    wt_item_t          s2_item_next;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

    always_comb
    begin
        vmask     = width_mask(cfg.value_width);
        bias      = cfg.value_signed ? top_bit(cfg.value_width) : '0;
        s1_a_next = (start_value & vmask) ^ bias;
        s1_b_next = (end_value & vmask) ^ bias;
        w_masked  = blend_weight & width_mask(cfg.weight_width);
        q65537    = w_masked[31:16]
                  - {15'd0, (w_masked[15:0] < w_masked[31:16])};
        if (cfg.weight_width == cfg.value_width)
        begin
            s1_w_next = w_masked;
        end
        else
        begin
            case (cfg.weight_width)
                WIDTH_8:  s1_w_next = {4{w_masked[7:0]}};
                WIDTH_16: s1_w_next = (cfg.value_width == WIDTH_32)
                                    ? {2{w_masked[15:0]}} : {16'd0, w_masked[15:0]};
                default:  s1_w_next = {16'd0, q65537};
            endcase
        end
    end

    always_comb
    begin
        need_div257 = (cfg.value_width == WIDTH_8) && (cfg.weight_width != WIDTH_8);
        q257        = s1_w_reg[15:8] - {7'd0, (s1_w_reg[7:0] < s1_w_reg[15:8])};
        s2_item_next.a  = s1_a_reg;
        s2_item_next.b  = s1_b_reg;
        s2_item_next.tw = need_div257 ? {24'd0, q257} : (s1_w_reg & vmask);
        s2_item_next.iw = vmask - s2_item_next.tw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_a_reg <= s1_a_next;
            s1_b_reg <= s1_b_next;
            s1_w_reg <= s1_w_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted item did not reach stage 1");

    a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((s2_item_reg.tw + s2_item_reg.iw) == width_mask(cfg.value_width)))
        else $error("weight and inverse weight do not sum to full scale");

endmodule

`default_nettype wire

### rtl/flp_mac.sv
// Stages 3-4: two products, then their sum with and without the rounding half.
// Depends on flp_pkg.
`default_nettype none

module flp_mac (
    input  wire                 clk,
    input  wire                 rst_n,
    input  flp_pkg::cfg_t       cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  flp_pkg::wt_item_t   in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output flp_pkg::mac_item_t  out_item
);
    import flp_pkg::*;

    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_pa_reg;
    logic [PROD_W-1:0] s3_pb_reg;
    logic              s4_valid_reg;
    mac_item_t         s4_item_reg;

    logic              s3_ready;
    logic              s4_ready;
    logic [PROD_W-1:0] s3_pa_next;
    logic [PROD_W-1:0] s3_pb_next;
    mac_item_t         s4_item_next;

    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign in_ready  = s3_ready;
    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

    always_comb
    begin
        s3_pa_next = PROD_W'(in_item.a) * PROD_W'(in_item.iw);
        s3_pb_next = PROD_W'(in_item.b) * PROD_W'(in_item.tw);
        s4_item_next.p  = s3_pa_reg + s3_pb_reg;
        s4_item_next.ph = s3_pa_reg + s3_pb_reg + PROD_W'(top_bit(cfg.value_width));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s3_ready)
        begin
            s3_pa_reg <= s3_pa_next;
            s3_pb_reg <= s3_pb_next;
        end
        if (s3_valid_reg && s4_ready)
        begin
            s4_item_reg <= s4_item_next;
        end
    end

endmodule

`default_nettype wire

### rtl/flp_round.sv
// Stages 5-6: double rounding shift by the value width, unbias, output register.
// Depends on flp_pkg.
`default_nettype none

module flp_round (
    input  wire                 clk,
    input  wire                 rst_n,
    input  flp_pkg::cfg_t       cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  flp_pkg::mac_item_t  in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [31:0]         blended_value
);
    import flp_pkg::*;

    logic              s5_valid_reg;
    logic [PROD_W-1:0] s5_t_reg;
    logic              s6_valid_reg;
    logic [DATA_W-1:0] s6_value_reg;

    logic              s5_ready;
    logic              s6_ready;
    logic [PROD_W-1:0] ph_shifted;
    logic [PROD_W-1:0] s5_t_next;
    logic [PROD_W-1:0] t_half;
    logic [PROD_W-1:0] t_shifted;
    logic [DATA_W-1:0] vmask;
    logic [DATA_W-1:0] bias;
    logic [DATA_W-1:0] s6_value_next;

    assign s6_ready      = !s6_valid_reg || out_ready;
    assign s5_ready      = !s5_valid_reg || s6_ready;
    assign in_ready      = s5_ready;
    assign out_valid     = s6_valid_reg;
    assign blended_value = s6_value_reg;

    always_comb
    begin
        case (cfg.value_width)
            WIDTH_8:  ph_shifted = in_item.ph >> 8;
            WIDTH_16: ph_shifted = in_item.ph >> 16;
            default:  ph_shifted = in_item.ph >> 32;
        endcase
        s5_t_next = ph_shifted + in_item.p;
    end

    always_comb
    begin
        vmask  = width_mask(cfg.value_width);
        bias   = cfg.value_signed ? top_bit(cfg.value_width) : '0;
        t_half = s5_t_reg + PROD_W'(top_bit(cfg.value_width));
        case (cfg.value_width)
            WIDTH_8:  t_shifted = t_half >> 8;
            WIDTH_16: t_shifted = t_half >> 16;
            default:  t_shifted = t_half >> 32;
        endcase
        s6_value_next = (t_shifted[DATA_W-1:0] & vmask) ^ bias;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_ready)
            begin
                s5_valid_reg <= in_valid;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s5_ready)
        begin
            s5_t_reg <= s5_t_next;
        end
        if (s5_valid_reg && s6_ready)
        begin
            s6_value_reg <= s6_value_next;
        end
    end

    a_upper_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg |-> !(((cfg.value_width == WIDTH_8) && (|s6_value_reg[31:8]))
                        || ((cfg.value_width == WIDTH_16) && (|s6_value_reg[31:16]))))
        else $error("result has bits above the value width");

    a_stage5_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && !s6_ready |=> s5_valid_reg && $stable(s5_t_reg))
        else $error("stage 5 item changed while stalled");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg && !out_ready |=> s6_valid_reg)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

### rtl/fixed_point_lerp_core.sv
// Top level of the fixed-point lerp core: configuration registers and the
// six-stage pipeline. Depends on flp_pkg, flp_weight_scale, flp_mac, flp_round.
//
// Usage:
//   Input channel in_valid/in_ready carries start_value, end_value and
//   blend_weight; output channel out_valid/out_ready carries blended_value.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets value width,
//   value signedness and weight width; write it only while the pipeline is
//   empty. Width code 3 selects 32 bits.
//   Throughput: one item per cycle while out_ready stays high. An accepted
//   item passes through six register stages before its result appears on
//   blended_value (two for weight rescale, two for the 32x32 products and
//   their sum, two for the rounding shifts).
//   Each stage holds a valid bit; when the receiver drops out_ready, items
//   stay in place and the pipeline keeps accepting until every stage is
//   full, so bubbles are squeezed out and nothing is lost or repeated.
//   Reset empties the pipeline and sets 8-bit unsigned values and an 8-bit
//   weight.
`default_nettype none

module fixed_point_lerp_core (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [flp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [flp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [31:0]                     start_value,
    input  wire  [31:0]                     end_value,
    input  wire  [31:0]                     blend_weight,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [31:0]                     blended_value
);
    import flp_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;

    logic      wt_valid;
    logic      wt_ready;
    wt_item_t  wt_item;
    logic      mac_valid;
    logic      mac_ready;
    mac_item_t mac_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VALUE_WIDTH:  cfg_next.value_width  = mode_to_width(cfg_data);
                CFG_VALUE_SIGNED: cfg_next.value_signed = cfg_data[0];
                CFG_WEIGHT_WIDTH: cfg_next.weight_width = mode_to_width(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_width  <= WIDTH_8;
            cfg_reg.value_signed <= 1'b0;
            cfg_reg.weight_width <= WIDTH_8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    flp_weight_scale u_weight_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_value  (start_value),
        .end_value    (end_value),
        .blend_weight (blend_weight),
        .out_valid    (wt_valid),
        .out_ready    (wt_ready),
        .out_item     (wt_item)
    );

    flp_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .in_item   (wt_item),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_item  (mac_item)
    );

    flp_round u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (mac_valid),
        .in_ready      (mac_ready),
        .in_item       (mac_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blended_value (blended_value)
    );

endmodule

`default_nettype wire
